/* rtl/descriptor_slot_table_defines.svh */
// Assertion macros shared by the descriptor slot table checkers.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef DESCRIPTOR_SLOT_TABLE_DEFINES_SVH
`define DESCRIPTOR_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSLT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSLT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/dslt_pkg.sv */
// Shared types, constants and helpers of the descriptor slot table.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package dslt_pkg;

  localparam int SLOTS    = 64;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int GRP_SIZE = 8;
  localparam int GRP_W    = 3;
  localparam int NGRP     = (SLOTS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int HANDLE_W = 32;

  typedef logic signed [7:0]    slot_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [HANDLE_W-1:0]  handle_t;

  localparam slot_t NONE_SLOT = 8'hFF;

  typedef enum logic [2:0] {
    CMD_ALLOC  = 3'd0,
    CMD_FREE   = 3'd1,
    CMD_GET    = 3'd2,
    CMD_DUP    = 3'd3,
    CMD_DUP_TO = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0] command;
    slot_t      slot;
    slot_t      target_slot;
    handle_t    handle_in;
  } dslt_in_t;

  typedef struct packed {
    logic [1:0] status;
    slot_t      slot_out;
    handle_t    handle_out;
    slot_t      lowest_free;
  } dslt_out_t;

  // Occupancy update toward the occupancy tracker.
  typedef struct packed {
    logic en;
    idx_t idx;
    logic set;
  } dslt_occ_upd_t;

  function automatic logic in_range(slot_t s);
    return (s >= 0) && (int'(s) < SLOTS);
  endfunction

endpackage

/* rtl/descriptor_slot_table.sv */
// Descriptor slot table top level: command sequencer, handle store, occupancy.
// Depends on dslt_pkg, dslt_mem and dslt_occ.
`timescale 1ns / 1ps
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+------------------------------------
//  in      | in  | in_valid_i / in_stall_o  | in_item_i   (command, slot, ...)
//  out     | out | out_valid_o / out_stall_i| out_item_o  (status, slot_out, ...)
//
//  Each item passes the steps idle (accept with the store read), read (decide and
//  write back), scan and done, while the registered lowest-free encoder over the
//  64 occupancy flags settles before done loads the result.
//  Reset clears the occupancy flags, so every slot reads empty; no clearing pass.
//  A stalled result holds in the output register while the next item is taken;
//  that item then waits in its last step until the register frees up.

module descriptor_slot_table
  import dslt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dslt_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dslt_out_t out_item_o
);

  state_e state_q, state_d;

  dslt_in_t  item_q;
  dslt_out_t res_q, res_d;
  dslt_out_t out_item_q;
  logic      out_valid_q, out_valid_d;
  slot_t     lowest_free_q, lowest_free_d;

  logic          accept;
  logic          load_out;
  logic          occ_bit;
  slot_t         enc_free;
  handle_t       rd_data;
  handle_t       src_h;
  logic          src_ok, dst_ok, lf_ok;
  idx_t          src_idx, dst_idx, lf_idx;
  logic          wr_en;
  idx_t          wr_idx;
  handle_t       wr_data;
  dslt_occ_upd_t occ_upd;

  assign accept = in_valid_i && (state_q == S_IDLE);

  // Store and occupancy.
  dslt_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .rd_en_i   (accept),
    .rd_idx_i  (in_item_i.slot[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  dslt_occ u_occ (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .upd_i         (occ_upd),
    .rd_idx_i      (src_idx),
    .occ_o         (occ_bit),
    .lowest_free_o (enc_free)
  );

  assign src_idx = item_q.slot[IDX_W-1:0];
  assign dst_idx = item_q.target_slot[IDX_W-1:0];
  assign lf_idx  = lowest_free_q[IDX_W-1:0];
  assign src_ok  = in_range(item_q.slot);
  assign dst_ok  = in_range(item_q.target_slot);
  assign lf_ok   = (lowest_free_q != NONE_SLOT);

  // An unoccupied slot reads as empty whatever the store holds.
  assign src_h = (src_ok && occ_bit) ? rd_data : '0;

  // Decide the command and its write-back; only acts in the read step.
  always_comb begin
    res_d             = '0;
    res_d.status      = ST_INVALID;
    res_d.slot_out    = NONE_SLOT;
    res_d.handle_out  = '0;
    res_d.lowest_free = NONE_SLOT;
    wr_en             = 1'b0;
    wr_idx            = lf_idx;
    wr_data           = item_q.handle_in;
    occ_upd           = '0;

    unique case (item_q.command)
      CMD_ALLOC: begin
        if (!lf_ok) begin
          res_d.status = ST_NOSPACE;
        end else begin
          wr_en          = 1'b1;
          res_d.status   = ST_OK;
          res_d.slot_out = lowest_free_q;
        end
      end
      CMD_FREE: begin
        if (src_ok) begin
          occ_upd.en   = 1'b1;
          occ_upd.idx  = src_idx;
          occ_upd.set  = 1'b0;
          res_d.status = ST_OK;
        end
      end
      CMD_GET: begin
        if (src_ok) begin
          res_d.handle_out = src_h;
          res_d.status     = ST_OK;
        end
      end
      CMD_DUP: begin
        if (src_ok && (src_h != '0)) begin
          if (!lf_ok) begin
            res_d.status = ST_NOSPACE;
          end else begin
            wr_en          = 1'b1;
            wr_data        = src_h;
            res_d.status   = ST_OK;
            res_d.slot_out = lowest_free_q;
          end
        end
      end
      CMD_DUP_TO: begin
        if (src_ok && dst_ok && (src_h != '0)) begin
          wr_en          = 1'b1;
          wr_idx         = dst_idx;
          wr_data        = src_h;
          res_d.status   = ST_OK;
          res_d.slot_out = item_q.target_slot;
        end
      end
      default: begin
        // Unused command codes: report invalid, touch nothing.
      end
    endcase

    // Hold the store outside the read step.
    if (state_q != S_READ) begin
      wr_en   = 1'b0;
      occ_upd = '0;
    end else if (wr_en) begin
      // A zero handle leaves the slot empty.
      occ_upd.en  = 1'b1;
      occ_upd.idx = wr_idx;
      occ_upd.set = (wr_data != '0);
    end
  end

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    load_out      = 1'b0;
    out_valid_d   = out_valid_q && out_stall_i;
    lowest_free_d = lowest_free_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // Encoder picks up the new occupancy at the end of this cycle.
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!(out_valid_q && out_stall_i)) begin
          load_out      = 1'b1;
          out_valid_d   = 1'b1;
          lowest_free_d = enc_free;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      lowest_free_q <= '0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      lowest_free_q <= lowest_free_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    if (state_q == S_READ) begin
      res_q <= res_d;
    end
    if (load_out) begin
      out_item_q <= '{status:      res_q.status,
                      slot_out:    res_q.slot_out,
                      handle_out:  res_q.handle_out,
                      lowest_free: enc_free};
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* rtl/dslt_mem.sv */
// Handle store: one write port, one registered read port.
// Depends on dslt_pkg.
`timescale 1ns / 1ps

module dslt_mem
  import dslt_pkg::*;
(
  input  logic    clk_i,
  input  logic    wr_en_i,
  input  idx_t    wr_idx_i,
  input  handle_t wr_data_i,
  input  logic    rd_en_i,
  input  idx_t    rd_idx_i,
  output handle_t rd_data_o
);

  handle_t mem_q [SLOTS];
  handle_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/dslt_occ.sv */
// Occupancy flags per slot and a registered two-level lowest-free encoder.
// Depends on dslt_pkg.
`timescale 1ns / 1ps

module dslt_occ
  import dslt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dslt_occ_upd_t upd_i,
  input  idx_t          rd_idx_i,
  output logic          occ_o,
  output slot_t         lowest_free_o
);

  localparam int PAD_W = NGRP * GRP_SIZE;

  logic [SLOTS-1:0]  occ_q;
  logic [PAD_W-1:0]  pad_occ;
  logic [NGRP-1:0]   grp_free_d, grp_free_q;
  logic [GRP_W-1:0]  grp_idx_d [NGRP];
  logic [GRP_W-1:0]  grp_idx_q [NGRP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (upd_i.en) begin
      occ_q[upd_i.idx] <= upd_i.set;
    end
  end

  assign occ_o = occ_q[rd_idx_i];

  // Padding bits past the last slot count as occupied.
  always_comb begin
    pad_occ = '1;
    pad_occ[SLOTS-1:0] = occ_q;
  end

  // First level: lowest free bit inside each group of eight.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_free_d[g] = 1'b0;
      grp_idx_d[g]  = '0;
      for (int i = GRP_SIZE - 1; i >= 0; i--) begin
        if (!pad_occ[g * GRP_SIZE + i]) begin
          grp_free_d[g] = 1'b1;
          grp_idx_d[g]  = GRP_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_free_q <= '1;
      for (int g = 0; g < NGRP; g++) begin
        grp_idx_q[g] <= '0;
      end
    end else begin
      grp_free_q <= grp_free_d;
      for (int g = 0; g < NGRP; g++) begin
        grp_idx_q[g] <= grp_idx_d[g];
      end
    end
  end

  // Second level: lowest group with a free slot.
  always_comb begin
    lowest_free_o = NONE_SLOT;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        lowest_free_o = slot_t'(g * GRP_SIZE) + slot_t'(grp_idx_q[g]);
      end
    end
  end

endmodule

/* rtl/dslt_chk.sv */
// Port-level checker for the descriptor slot table, bound to the top level.
// Depends on dslt_pkg and descriptor_slot_table_defines.svh.
`timescale 1ns / 1ps
`include "descriptor_slot_table_defines.svh"

module dslt_chk
  import dslt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input dslt_in_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input dslt_out_t out_item_o
);

  `DSLT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `DSLT_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_item_o), "result changed while stalled")
  `DSLT_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "second item taken while one is in work")
  `DSLT_ASSERT_NOW(a_nospace_full, clk_i, rst_ni, out_valid_o && (out_item_o.status == ST_NOSPACE), out_item_o.lowest_free == NONE_SLOT, "no-space reported with a free slot")
  `DSLT_ASSERT_NOW(a_fail_clean, clk_i, rst_ni, out_valid_o && (out_item_o.status != ST_OK), (out_item_o.slot_out == NONE_SLOT) && (out_item_o.handle_out == '0), "failed item carries a slot or handle")

endmodule

bind descriptor_slot_table dslt_chk u_dslt_chk (.*);
